// File: hw/rtl/lfsr_kbc_pkg.sv
// Shared types and constants for the LFSR keystream byte cipher.
// Used by every module of the block through scoped names; no dependencies.
package lfsr_kbc_pkg;

  localparam int LFSR_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int STEPS    = 8;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 6;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MANUAL = 2'd0,
    MODE_16     = 2'd1,
    MODE_17     = 2'd2,
    MODE_32     = 2'd3
  } lfsr_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_SEED     = 2'd1,
    CFG_TAP_MASK = 2'd2,
    CFG_REG_LEN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    lfsr_mode_t        mode;
    logic [LFSR_W-1:0] seed;
    logic [LFSR_W-1:0] tap_mask;
    logic [LEN_W-1:0]  reg_len;
  } cfg_t;

  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;
  localparam logic [POS_W-1:0] POS_16  = 5'd15;
  localparam logic [POS_W-1:0] POS_17  = 5'd16;
  localparam logic [POS_W-1:0] POS_32  = 5'd31;

endpackage

// File: hw/rtl/lfsr_kbc_step.sv
// One right-shift step of the Fibonacci shift register for all four modes.
// Depends on lfsr_kbc_pkg.
module lfsr_kbc_step (
  input  lfsr_kbc_pkg::cfg_t                    cfg,
  input  logic [lfsr_kbc_pkg::LFSR_W-1:0]       state,
  output logic [lfsr_kbc_pkg::LFSR_W-1:0]       state_next
);

  logic                               fb;
  logic [lfsr_kbc_pkg::POS_W-1:0]     pos;
  logic [lfsr_kbc_pkg::POS_W-1:0]     len_m1;

  assign len_m1 = cfg.reg_len[lfsr_kbc_pkg::POS_W-1:0] - lfsr_kbc_pkg::POS_W'(1);

  always_comb begin
    case (cfg.mode)
      lfsr_kbc_pkg::MODE_16: begin
        fb  = state[15] ^ state[14] ^ state[12] ^ state[3];
        pos = lfsr_kbc_pkg::POS_16;
      end
      lfsr_kbc_pkg::MODE_17: begin
        fb  = state[16] ^ state[13];
        pos = lfsr_kbc_pkg::POS_17;
      end
      lfsr_kbc_pkg::MODE_32: begin
        fb  = state[31] ^ state[21] ^ state[1] ^ state[0];
        pos = lfsr_kbc_pkg::POS_32;
      end
      default: begin
        fb = ^(state & cfg.tap_mask);
        // zero or oversized length falls back to the full register
        if (cfg.reg_len == '0 || cfg.reg_len > lfsr_kbc_pkg::LEN_MAX) begin
          pos = lfsr_kbc_pkg::POS_32;
        end else begin
          pos = len_m1;
        end
      end
    endcase
  end

  // feedback is ORed in, so high bits shifting down merge with it
  assign state_next = (lfsr_kbc_pkg::LFSR_W'(fb) << pos) | (state >> 1);

endmodule

// File: hw/rtl/lfsr_kbc_keygen.sv
// Eight chained shift steps producing one keystream byte and the next state.
// Depends on lfsr_kbc_pkg and lfsr_kbc_step.
module lfsr_kbc_keygen (
  input  lfsr_kbc_pkg::cfg_t                    cfg,
  input  logic                                  start,
  input  logic [lfsr_kbc_pkg::LFSR_W-1:0]       state,
  output logic [lfsr_kbc_pkg::LFSR_W-1:0]       state_next,
  output logic [lfsr_kbc_pkg::BYTE_W-1:0]       ks_byte
);

  logic [lfsr_kbc_pkg::LFSR_W-1:0] chain [0:lfsr_kbc_pkg::STEPS];

  assign chain[0] = start ? cfg.seed : state;

  for (genvar i = 0; i < lfsr_kbc_pkg::STEPS; i++) begin : g_step
    lfsr_kbc_step u_step (
      .cfg        (cfg),
      .state      (chain[i]),
      .state_next (chain[i+1])
    );
    assign ks_byte[i] = chain[i+1][0];
  end

  assign state_next = chain[lfsr_kbc_pkg::STEPS];

endmodule

// File: hw/rtl/lfsr_keystream_byte_cipher_core.sv
// LFSR keystream byte cipher, top level. Depends on lfsr_kbc_pkg, lfsr_kbc_keygen.
// Pipeline: 2 register stages, the input register and then the result register.
// Throughput: one item per cycle while out_stall does not hold the pipeline; the shift
// register updates as each item moves into the result register, so the next item sees it.
// Reset (rst_n low, synchronous): pipeline empty, shift register zero,
// mode 32-bit, seed and tap mask zero, register length 32.
module lfsr_keystream_byte_cipher_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_start_message,
  input  logic [lfsr_kbc_pkg::BYTE_W-1:0]        in_data_in,
  input  logic                                   in_last_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lfsr_kbc_pkg::BYTE_W-1:0]        out_data_out,
  output logic [lfsr_kbc_pkg::BYTE_W-1:0]        out_keystream_byte,
  output logic                                   out_last_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lfsr_kbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfsr_kbc_pkg::LFSR_W-1:0]        cfg_data
);

  lfsr_kbc_pkg::cfg_t                     cfg_r;
  logic [lfsr_kbc_pkg::LFSR_W-1:0]        lfsr_r;
  logic [lfsr_kbc_pkg::LFSR_W-1:0]        lfsr_nxt;
  logic [lfsr_kbc_pkg::BYTE_W-1:0]        ks_nxt;

  logic                                   s1_vld_r;
  logic                                   s1_start_r;
  logic [lfsr_kbc_pkg::BYTE_W-1:0]        s1_data_r;
  logic                                   s1_last_r;

  logic                                   out_vld_r;
  logic [lfsr_kbc_pkg::BYTE_W-1:0]        out_data_r;
  logic [lfsr_kbc_pkg::BYTE_W-1:0]        out_ks_r;
  logic                                   out_last_r;

  logic out_load;
  logic s1_move;
  logic in_take;

  assign out_load = !out_vld_r || !out_stall;
  assign s1_move  = s1_vld_r && out_load;
  assign in_stall = s1_vld_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= lfsr_kbc_pkg::MODE_32;
      cfg_r.seed     <= '0;
      cfg_r.tap_mask <= '0;
      cfg_r.reg_len  <= lfsr_kbc_pkg::LEN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfsr_kbc_pkg::CFG_MODE:
          cfg_r.mode <= lfsr_kbc_pkg::lfsr_mode_t'(cfg_data[lfsr_kbc_pkg::MODE_W-1:0]);
        lfsr_kbc_pkg::CFG_SEED:     cfg_r.seed     <= cfg_data;
        lfsr_kbc_pkg::CFG_TAP_MASK: cfg_r.tap_mask <= cfg_data;
        lfsr_kbc_pkg::CFG_REG_LEN:  cfg_r.reg_len  <= cfg_data[lfsr_kbc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!s1_vld_r || out_load) begin
      s1_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start_r <= in_start_message;
      s1_data_r  <= in_data_in;
      s1_last_r  <= in_last_byte;
    end
  end

  lfsr_kbc_keygen u_keygen (
    .cfg        (cfg_r),
    .start      (s1_start_r),
    .state      (lfsr_r),
    .state_next (lfsr_nxt),
    .ks_byte    (ks_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= '0;
    end else if (s1_move) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= s1_data_r ^ ks_nxt;
      out_ks_r   <= ks_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_data_out       = out_data_r;
  assign out_keystream_byte = out_ks_r;
  assign out_last_out       = out_last_r;

`ifndef SYNTHESIS
  // shift register only advances with an item leaving the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(lfsr_r))
    else $error("shift register changed without an item");

  // a stall upstream only comes from a full input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // result byte is always data combined with the keystream shown beside it
  a_xor_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> (out_data_r ^ out_ks_r) == $past(s1_data_r))
    else $error("result byte does not match keystream");
`endif

endmodule
